// ===== hdl/w2s_pkg.sv =====
// shared constants and types for the 2d wave stencil step block
// register indexes, configuration widths and reset values
// no dependencies
`default_nettype none

package w2s_pkg;

  localparam int GRID_W    = 11;
  localparam int K_W       = 16;
  localparam int K_FRAC    = 16;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 1;
  localparam int MIN_GRID  = 3;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;
  localparam logic [K_W-1:0]    K_RESET    = 16'd16384;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GRID_SIZE = 1'b0,
    REG_COURANT   = 1'b1
  } w2s_reg_t;

endpackage

`default_nettype wire

// ===== hdl/w2s_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// read-first on a same-address read and write; no dependencies
`default_nettype none

module w2s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wave_2d_stencil_step.sv =====
// top level of the 2d wave equation step, five-point stencil, mirrored edges
// depends on w2s_pkg and w2s_ram
//
// usage:
//   in_*  : one grid point per transfer in raster order; tdata holds the value at
//           time t (low field) and at time t-1 (high field)
//   out_* : next value per point in raster order, tlast on the last point of a frame
//   cfg_* : register writes (grid size, courant coefficient), only while idle
// a point needs the row below it, so row r-1 comes out while row r goes in; the
// last row of a frame comes out while the first row of the next frame goes in.
// the first row after reset produces no output.
// the result caused by an accepted transfer passes the ram read, the laplacian, the multiply,
// and round and saturate into the output register before it is on out_tvalid.
// throughput: one point per cycle while out_tready holds, bounded by the one write port and
// one read port of each ram copy; the cur row banks are duplicated to get two reads per bank.
// reset: position counters, row slot and pipeline valids clear; row memories are
// not cleared and need no clearing pass.
// stall: each stage holds while the next is full; empty stages keep taking input,
// so in_tready stays high while out_tvalid is low.
`default_nettype none

module wave_2d_stencil_step
  import w2s_pkg::*;
#(
  parameter int MAX_GRID    = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // in_tdata: current_value, previous_value (low bits first)
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0]         in_tdata,
  // out_tdata: next_value
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]           out_tdata,
  output logic                                       out_tlast,
  input  wire                                        cfg_we,
  input  wire  [REG_IDX_W-1:0]                       cfg_index,
  input  wire  [CFG_W-1:0]                           cfg_data
);

  // sample width used inside; wider samples keep only this many low bits
  localparam int SW     = (SAMPLE_BITS > 44) ? 44 : SAMPLE_BITS;
  localparam int OUT_W  = ((SAMPLE_BITS+7)/8)*8;
  localparam int ADDR_W = $clog2(MAX_GRID);
  localparam int NW     = ADDR_W + 1;
  localparam int CMP_W  = (NW > GRID_W) ? NW + 1 : GRID_W + 1;
  localparam int LW     = SW + 3;           // laplacian
  localparam int MW     = LW + K_W + 1;     // product with k
  localparam int PW     = MW + 1;           // product plus rounding half
  localparam int TW     = PW - K_FRAC;      // scaled term
  localparam int BW     = SW + 2;           // 2*center - prev
  localparam int XW     = TW + 1;           // final sum

  localparam logic signed [XW-1:0] SAT_MAX = XW'($signed({1'b0, {(SW-1){1'b1}}}));
  localparam logic signed [XW-1:0] SAT_MIN = XW'($signed({1'b1, {(SW-1){1'b0}}}));

  // configuration registers
  logic [GRID_W-1:0] grid_size_r;
  logic [K_W-1:0]    courant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_RESET;
      courant_r   <= K_RESET;
    end else if (cfg_we) begin
      case (w2s_reg_t'(cfg_index))
        REG_GRID_SIZE: grid_size_r <= cfg_data[GRID_W-1:0];
        REG_COURANT:   courant_r   <= cfg_data[K_W-1:0];
        default:       ;
      endcase
    end
  end

  // effective grid size, clamped to [3, MAX_GRID]
  logic [CMP_W-1:0] gs_ext;
  logic [NW-1:0]    n_val;
  logic [NW-1:0]    n_m1;
  logic [NW-1:0]    n_m2;

  assign gs_ext = CMP_W'(grid_size_r);

  always_comb begin
    if (gs_ext < CMP_W'(MIN_GRID)) begin
      n_val = NW'(MIN_GRID);
    end else if (gs_ext > CMP_W'(MAX_GRID)) begin
      n_val = NW'(MAX_GRID);
    end else begin
      n_val = NW'(gs_ext);
    end
  end

  assign n_m1 = n_val - NW'(1);
  assign n_m2 = n_val - NW'(2);

  // ---------------------------------------------------------------
  // position tracking and ram access on the accepted transfer
  // ---------------------------------------------------------------
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ADDR_W-1:0] row_r, row_nxt;
  logic              slot_r, slot_nxt;   // bank receiving the incoming row
  logic              held_r, held_nxt;   // a full frame is held, its last row pending

  logic [NW-1:0]     col_ext;
  logic [NW-1:0]     col_p1;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] right_addr;
  logic              emit;
  logic              accept;

  logic [SW-1:0]     in_cur;
  logic [SW-1:0]     in_prev;

  assign in_cur  = in_tdata[SW-1:0];
  assign in_prev = in_tdata[SAMPLE_BITS +: SW];

  assign accept   = in_tvalid && in_tready;
  assign col_ext  = {1'b0, col_r};
  assign col_p1   = col_ext + NW'(1);
  assign last_col = col_ext >= n_m1;
  assign last_row = {1'b0, row_r} >= n_m1;
  assign emit     = (row_r != '0) || held_r;

  // right neighbor mirrors to n-2 past the row end
  assign right_addr = (col_p1 < n_val) ? col_p1[ADDR_W-1:0] : n_m2[ADDR_W-1:0];

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    held_nxt = held_r;
    if (accept) begin
      if (last_col) begin
        col_nxt  = '0;
        slot_nxt = ~slot_r;
        if (last_row) begin
          row_nxt  = '0;
          held_nxt = 1'b1;
        end else begin
          row_nxt = row_r + ADDR_W'(1);
        end
      end else begin
        col_nxt = col_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= 1'b0;
      held_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      held_r <= held_nxt;
    end
  end

  // two row banks, each kept in two copies so a bank gives two reads per cycle:
  // copy a reads the column itself, copy b the right neighbor
  logic [SW-1:0] bank_a_q [2];
  logic [SW-1:0] bank_b_q [2];
  logic [SW-1:0] prev_q;

  for (genvar g = 0; g < 2; g++) begin : g_bank
    w2s_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_GRID)
    ) u_row_a (
      .clk     (clk),
      .wr_en   (accept && (slot_r == 1'(g))),
      .wr_addr (col_r),
      .wr_data (in_cur),
      .rd_en   (accept),
      .rd_addr (col_r),
      .rd_data (bank_a_q[g])
    );

    w2s_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_GRID)
    ) u_row_b (
      .clk     (clk),
      .wr_en   (accept && (slot_r == 1'(g))),
      .wr_addr (col_r),
      .wr_data (in_cur),
      .rd_en   (accept),
      .rd_addr (right_addr),
      .rd_data (bank_b_q[g])
    );
  end

  // t-1 values of the row last received; read-first gives the older row
  w2s_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_GRID)
  ) u_prev_row (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (in_prev),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (prev_q)
  );

  // ---------------------------------------------------------------
  // pipeline handshake: each stage moves when the next has room
  // ---------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic out_ready, s3_ready, s2_ready;

  assign out_ready = !out_valid_r || out_tready;
  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= accept && emit;   // first row after reset has nothing to emit
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: ram data arrives, form laplacian and 2*center - prev
  // ---------------------------------------------------------------
  logic [SW-1:0] s1_cur_r;
  logic          s1_row0_r;
  logic          s1_row1_r;
  logic          s1_col0_r;
  logic          s1_slot_r;
  logic          s1_last_r;
  logic [SW-1:0] left_r;    // center of the previous column of this row

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= in_cur;
      s1_row0_r <= (row_r == '0);
      s1_row1_r <= (row_r == ADDR_W'(1));
      s1_col0_r <= (col_r == '0);
      s1_slot_r <= slot_r;
      s1_last_r <= (row_r == '0) && last_col;
    end
  end

  logic signed [SW-1:0] old_a_s, center_s, right_s, left_s, cur_s, prv_s;
  logic signed [SW-1:0] up_s, down_s;
  logic signed [LW-1:0] lap_nxt;
  logic signed [BW-1:0] base_nxt;

  assign old_a_s  = $signed(s1_slot_r ? bank_a_q[1] : bank_a_q[0]);
  assign center_s = $signed(s1_slot_r ? bank_a_q[0] : bank_a_q[1]);
  assign right_s  = $signed(s1_slot_r ? bank_b_q[0] : bank_b_q[1]);
  assign left_s   = s1_col0_r ? right_s : $signed(left_r);   // column 0 mirrors to column 1
  assign cur_s    = $signed(s1_cur_r);
  assign prv_s    = $signed(prev_q);

  // last row of the held frame mirrors row n-2 (two back), the top row mirrors incoming row 1
  always_comb begin
    if (s1_row0_r) begin
      up_s   = old_a_s;
      down_s = old_a_s;
    end else if (s1_row1_r) begin
      up_s   = cur_s;
      down_s = cur_s;
    end else begin
      up_s   = old_a_s;
      down_s = cur_s;
    end
  end

  assign lap_nxt  = LW'(up_s) + LW'(down_s) + LW'(left_s) + LW'(right_s)
                  - (LW'(center_s) <<< 2);
  assign base_nxt = (BW'(center_s) <<< 1) - BW'(prv_s);

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      left_r <= center_s;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: multiply by k
  // ---------------------------------------------------------------
  logic signed [LW-1:0] s2_lap_r;
  logic signed [BW-1:0] s2_base_r;
  logic                 s2_last_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_lap_r  <= lap_nxt;
      s2_base_r <= base_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  logic signed [MW-1:0] prod_nxt;

  assign prod_nxt = MW'(s2_lap_r) * MW'($signed({1'b0, courant_r}));

  // ---------------------------------------------------------------
  // stage 3: round to nearest (ties up), add, saturate
  // ---------------------------------------------------------------
  logic signed [MW-1:0] s3_prod_r;
  logic signed [BW-1:0] s3_base_r;
  logic                 s3_last_r;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_prod_r <= prod_nxt;
      s3_base_r <= s2_base_r;
      s3_last_r <= s2_last_r;
    end
  end

  logic signed [PW-1:0] rnd;
  logic signed [TW-1:0] term;
  logic signed [XW-1:0] sum;
  logic        [SW-1:0] sat_nxt;

  assign rnd  = PW'(s3_prod_r) + (PW'(1) <<< (K_FRAC - 1));
  assign term = $signed(rnd[PW-1:K_FRAC]);
  assign sum  = XW'(term) + XW'(s3_base_r);

  always_comb begin
    if (sum > SAT_MAX) begin
      sat_nxt = SAT_MAX[SW-1:0];
    end else if (sum < SAT_MIN) begin
      sat_nxt = SAT_MIN[SW-1:0];
    end else begin
      sat_nxt = sum[SW-1:0];
    end
  end

  // output register
  logic [SW-1:0] out_value_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_value_r <= sat_nxt;
      out_last_r  <= s3_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_value_r);
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/w2s_checker.sv =====
// port-level checks for the 2d wave stencil step, bound to the top level
// depends on wave_2d_stencil_step
`default_nettype none

module w2s_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  input wire                                out_tlast
);

  // a stalled result holds its value and frame mark
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with no result waiting every stage has room, so input must be taken
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output empty");

  // a pending input with ready low implies a result is waiting and stalled
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked without output stall");

endmodule

bind wave_2d_stencil_step w2s_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_w2s_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
